FILE: hdl/button_gesture_classifier_unit_defines.svh
// Assertion macros shared by the button gesture classifier RTL.
`ifndef BUTTON_GESTURE_CLASSIFIER_UNIT_DEFINES_SVH
`define BUTTON_GESTURE_CLASSIFIER_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
// Property must hold at every clock edge outside reset.
`define BGC_ASSERT(name, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("bgc assertion failed");
// Condition must never be true outside reset.
`define BGC_NEVER(name, cond) \
    name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("bgc forbidden condition seen");
`else
`define BGC_ASSERT(name, prop)
`define BGC_NEVER(name, cond)
`endif
`endif

FILE: hdl/bgc_pkg.sv
// Types, codes and reset values for the button gesture classifier.
`default_nettype none
package bgc_pkg;

    localparam int TIME_BITS_DEF = 32;
    localparam int ADDR_W        = 4;
    localparam int DATA_W        = 32;
    localparam int MAX_EVENTS    = 4;

    // register indexes (byte address = 4 * index)
    localparam logic [1:0] REG_DEBOUNCE   = 2'd0;
    localparam logic [1:0] REG_LONG_PRESS = 2'd1;
    localparam logic [1:0] REG_DOUBLE_TAP = 2'd2;
    localparam logic [1:0] REG_TAP_MARGIN = 2'd3;

    localparam logic [9:0]  DEBOUNCE_RST   = 10'd60;
    localparam logic [15:0] LONG_PRESS_RST = 16'd3000;
    localparam logic [11:0] DOUBLE_TAP_RST = 12'd400;
    localparam logic [7:0]  TAP_MARGIN_RST = 8'd10;

    // event codes
    localparam logic [2:0] EV_UP     = 3'd0;
    localparam logic [2:0] EV_DOWN   = 3'd1;
    localparam logic [2:0] EV_TAP    = 3'd2;
    localparam logic [2:0] EV_DOUBLE = 3'd3;
    localparam logic [2:0] EV_LONG   = 3'd4;

    typedef struct packed {
        logic [9:0]  debounce_win;
        logic [15:0] long_press_ms;
        logic [11:0] double_tap_ms;
        logic [7:0]  tap_margin_ms;
    } cfg_t;

    typedef struct packed {
        logic up_edge;
        logic down_edge;
        logic show_edge;
        logic show_level;
    } tick_t;

    typedef struct packed {
        logic [2:0] event_code;
        logic       last_event;
    } evt_t;

    // events caused by one tick, in emission order
    typedef struct packed {
        logic [MAX_EVENTS-1:0][2:0] code;
        logic [2:0]                 cnt;
    } ev_list_t;

endpackage
`default_nettype wire

FILE: hdl/bgc_regs.sv
// APB configuration registers of the button gesture classifier.
`default_nettype none
module bgc_regs
    import bgc_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [DATA_W-1:0] pwdata,
    output logic      [DATA_W-1:0] prdata,
    output logic                   pready,
    output cfg_t                   cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;
    logic wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite;
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (paddr[3:2])
                REG_DEBOUNCE:   cfg_next.debounce_win  = pwdata[9:0];
                REG_LONG_PRESS: cfg_next.long_press_ms = pwdata[15:0];
                REG_DOUBLE_TAP: cfg_next.double_tap_ms = pwdata[11:0];
                REG_TAP_MARGIN: cfg_next.tap_margin_ms = pwdata[7:0];
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            REG_DEBOUNCE:   prdata = {22'd0, cfg_reg.debounce_win};
            REG_LONG_PRESS: prdata = {16'd0, cfg_reg.long_press_ms};
            REG_DOUBLE_TAP: prdata = {20'd0, cfg_reg.double_tap_ms};
            REG_TAP_MARGIN: prdata = {24'd0, cfg_reg.tap_margin_ms};
            default:        prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.debounce_win  <= DEBOUNCE_RST;
            cfg_reg.long_press_ms <= LONG_PRESS_RST;
            cfg_reg.double_tap_ms <= DOUBLE_TAP_RST;
            cfg_reg.tap_margin_ms <= TAP_MARGIN_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule
`default_nettype wire

FILE: hdl/bgc_core.sv
// Tick input register, gesture state and per-tick event decode.
`default_nettype none
`include "button_gesture_classifier_unit_defines.svh"
module bgc_core
    import bgc_pkg::*;
#(
    parameter int TIME_BITS = TIME_BITS_DEF
)
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire cfg_t     cfg,
    input  wire logic     tick_valid,
    output logic          tick_stall,
    input  wire tick_t    tick,
    input  wire logic     buf_ready,
    output logic          push,
    output ev_list_t      push_list
);

    localparam int W = TIME_BITS;

    // input register
    logic  s1_valid_reg;
    logic  s1_valid_next;
    tick_t s1_tick_reg;
    logic  load;
    logic  go;

    // gesture state
    logic [W-1:0] clock_reg,   clock_next;
    logic [W-1:0] up_last_reg, up_last_next;
    logic [W-1:0] dn_last_reg, dn_last_next;
    logic [W-1:0] sh_last_reg, sh_last_next;
    logic         held_reg,    held_next;
    logic         lrep_reg,    lrep_next;
    logic [W-1:0] pstart_reg,  pstart_next;
    logic         tapw_reg,    tapw_next;
    logic [W-1:0] taprel_reg,  taprel_next;
    logic         armed_reg,   armed_next;
    logic [W-1:0] dline_reg,   dline_next;

    logic [W-1:0] now;
    logic [W-1:0] debounce_w;
    logic [W-1:0] long_w;
    logic [W-1:0] dtap_w;
    logic [W-1:0] tap_delay_w;
    logic         up_ok, dn_ok, sh_ok;
    logic         ev_dbl, ev_long, ev_tap;
    logic [3:0]   ev_flag;
    logic [3:0][2:0] ev_cand;
    ev_list_t     list;
    logic [2:0]   n;

    assign now         = clock_reg;
    assign debounce_w  = {{(W-10){1'b0}}, cfg.debounce_win};
    assign long_w      = {{(W-16){1'b0}}, cfg.long_press_ms};
    assign dtap_w      = {{(W-12){1'b0}}, cfg.double_tap_ms};
    assign tap_delay_w = {{(W-13){1'b0}},
                          ({1'b0, cfg.double_tap_ms} + {5'd0, cfg.tap_margin_ms})};

    // debounce: wrapped gap since last accepted edge
    assign up_ok = s1_tick_reg.up_edge   && ((now - up_last_reg) >= debounce_w);
    assign dn_ok = s1_tick_reg.down_edge && ((now - dn_last_reg) >= debounce_w);
    assign sh_ok = s1_tick_reg.show_edge && ((now - sh_last_reg) >= debounce_w);

    always_comb
    begin
        clock_next   = now + {{(W-1){1'b0}}, 1'b1};
        up_last_next = up_ok ? now : up_last_reg;
        dn_last_next = dn_ok ? now : dn_last_reg;
        sh_last_next = sh_ok ? now : sh_last_reg;
        held_next    = held_reg;
        lrep_next    = lrep_reg;
        pstart_next  = pstart_reg;
        tapw_next    = tapw_reg;
        taprel_next  = taprel_reg;
        armed_next   = armed_reg;
        dline_next   = dline_reg;
        ev_dbl       = 1'b0;
        ev_long      = 1'b0;
        ev_tap       = 1'b0;

        // show edge
        if (sh_ok)
        begin
            if (s1_tick_reg.show_level)
            begin
                held_next   = 1'b1;
                lrep_next   = 1'b0;
                pstart_next = now;
                armed_next  = 1'b1;
                dline_next  = now + long_w;
            end
            else
            begin
                if (held_reg && !lrep_reg)
                begin
                    if (tapw_reg && ((now - taprel_reg) <= dtap_w))
                    begin
                        tapw_next = 1'b0;
                        ev_dbl    = 1'b1;
                    end
                    else
                    begin
                        tapw_next   = 1'b1;
                        taprel_next = now;
                        armed_next  = 1'b1;
                        dline_next  = now + tap_delay_w;
                    end
                end
                held_next = 1'b0;
            end
        end

        // deadline check sees the state left by the show edge
        if (armed_next && (dline_next == now))
        begin
            armed_next = 1'b0;
            if (held_next && !lrep_next && ((now - pstart_next) >= long_w))
            begin
                lrep_next = 1'b1;
                tapw_next = 1'b0;
                ev_long   = 1'b1;
            end
            else if (tapw_next && ((now - taprel_next) > dtap_w))
            begin
                tapw_next = 1'b0;
                ev_tap    = 1'b1;
            end
        end
    end

    // pack events in order: up, down, double tap, then long press or tap
    assign ev_flag    = {ev_long | ev_tap, ev_dbl, dn_ok, up_ok};
    assign ev_cand[0] = EV_UP;
    assign ev_cand[1] = EV_DOWN;
    assign ev_cand[2] = EV_DOUBLE;
    assign ev_cand[3] = ev_long ? EV_LONG : EV_TAP;

    always_comb
    begin
        list = '0;
        n    = 3'd0;
        for (int i = 0; i < MAX_EVENTS; i++)
        begin
            if (ev_flag[i])
            begin
                list.code[n[1:0]] = ev_cand[i];
                n = n + 3'd1;
            end
        end
        list.cnt = n;
    end

    // ticks without events need no room in the event buffer
    assign go            = s1_valid_reg && ((list.cnt == 3'd0) || buf_ready);
    assign tick_stall    = s1_valid_reg && !go;
    assign load          = tick_valid && !tick_stall;
    assign push          = go && (list.cnt != 3'd0);
    assign push_list     = list;
    assign s1_valid_next = load ? 1'b1 : (go ? 1'b0 : s1_valid_reg);

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            s1_tick_reg <= tick;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            clock_reg    <= '0;
            up_last_reg  <= '0;
            dn_last_reg  <= '0;
            sh_last_reg  <= '0;
            held_reg     <= 1'b0;
            lrep_reg     <= 1'b0;
            pstart_reg   <= '0;
            tapw_reg     <= 1'b0;
            taprel_reg   <= '0;
            armed_reg    <= 1'b0;
            dline_reg    <= '0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            if (go)
            begin
                clock_reg   <= clock_next;
                up_last_reg <= up_last_next;
                dn_last_reg <= dn_last_next;
                sh_last_reg <= sh_last_next;
                held_reg    <= held_next;
                lrep_reg    <= lrep_next;
                pstart_reg  <= pstart_next;
                tapw_reg    <= tapw_next;
                taprel_reg  <= taprel_next;
                armed_reg   <= armed_next;
                dline_reg   <= dline_next;
            end
        end
    end

    // one clock step per processed tick
    `BGC_ASSERT(a_clock_step, go |=> (clock_reg == $past(clock_reg) + 1'b1))
    // never push into a buffer that has no room
    `BGC_ASSERT(a_push_room, push |-> buf_ready)

endmodule
`default_nettype wire

FILE: hdl/bgc_evbuf.sv
// Event buffer: holds one tick's events and sends them one per cycle while evt_stall is low.
`default_nettype none
`include "button_gesture_classifier_unit_defines.svh"
module bgc_evbuf
    import bgc_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     push,
    input  wire ev_list_t push_list,
    output logic          buf_ready,
    output logic          evt_valid,
    input  wire logic     evt_stall,
    output evt_t          evt
);

    logic                       buf_valid_reg, buf_valid_next;
    logic [1:0]                 idx_reg,       idx_next;
    logic [2:0]                 cnt_reg;
    logic [MAX_EVENTS-1:0][2:0] code_reg;
    logic                       pop;
    logic                       last;

    assign last      = (({1'b0, idx_reg} + 3'd1) == cnt_reg);
    assign pop       = buf_valid_reg && !evt_stall;
    assign buf_ready = !buf_valid_reg || (pop && last);

    assign evt_valid        = buf_valid_reg;
    assign evt.event_code   = code_reg[idx_reg];
    assign evt.last_event   = last;

    always_comb
    begin
        buf_valid_next = buf_valid_reg;
        idx_next       = idx_reg;
        if (push)
        begin
            buf_valid_next = 1'b1;
            idx_next       = 2'd0;
        end
        else if (pop)
        begin
            if (last)
            begin
                buf_valid_next = 1'b0;
            end
            else
            begin
                idx_next = idx_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            code_reg <= push_list.code;
            cnt_reg  <= push_list.cnt;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            buf_valid_reg <= 1'b0;
            idx_reg       <= 2'd0;
        end
        else
        begin
            buf_valid_reg <= buf_valid_next;
            idx_reg       <= idx_next;
        end
    end

    // held list always has one to four events and the read index inside it
    `BGC_ASSERT(a_cnt_range, buf_valid_reg |-> (cnt_reg != 3'd0 && cnt_reg <= 3'd4))
    `BGC_NEVER(a_idx_beyond, buf_valid_reg && ({1'b0, idx_reg} >= cnt_reg))
    // index only moves forward while an event is taken
    `BGC_ASSERT(a_idx_hold, (buf_valid_reg && evt_stall && !push) |=> $stable(idx_reg))

endmodule
`default_nettype wire

FILE: hdl/button_gesture_classifier_unit.sv
// Top level of the button gesture classifier.
//
// Usage:
//   tick channel (tick_valid / tick_stall / tick): one item per millisecond tick,
//     carrying up and down press edges and the show button edge and level.
//   evt channel (evt_valid / evt_stall / evt): one item per gesture event;
//     last_event marks the final event caused by a tick. Ticks with no
//     event produce no item.
//   APB port: four registers at byte addresses 0x0, 0x4, 0x8, 0xC
//     (debounce, long press, double tap, tap margin). Write only while idle.
// Path: an accepted tick is registered in the input register and decoded
//   from it; its events are registered in the event buffer and driven on evt.
// Throughput: one tick per cycle while ticks carry at most one event and
//   evt_stall is low; a tick with several events holds the event output until
//   each is sent, as the event buffer takes the next tick's list only once the last event leaves.
// Reset: registers return to defaults, the ms clock and all edge times go
//   to zero, no deadline armed, both channels empty.
// Stall: evt_stall freezes the event buffer; the decode stage then waits on any
//   tick with events, and tick_stall rises while such a tick holds the input register.
`default_nettype none
module button_gesture_classifier_unit
    import bgc_pkg::*;
#(
    parameter int TIME_BITS = TIME_BITS_DEF
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    // configuration
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [DATA_W-1:0] pwdata,
    output logic      [DATA_W-1:0] prdata,
    output logic                   pready,
    // ticks in
    input  wire logic              tick_valid,
    output logic                   tick_stall,
    input  wire tick_t             tick,
    // events out
    output logic                   evt_valid,
    input  wire logic              evt_stall,
    output evt_t                   evt
);

    cfg_t     cfg;
    logic     buf_ready;
    logic     push;
    ev_list_t push_list;

    bgc_regs u_regs
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // state and decode: one tick per cycle while the event buffer has room
    bgc_core #(
        .TIME_BITS (TIME_BITS)
    ) u_core
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .tick_valid (tick_valid),
        .tick_stall (tick_stall),
        .tick       (tick),
        .buf_ready  (buf_ready),
        .push       (push),
        .push_list  (push_list)
    );

    // result register: serializes a tick's events
    bgc_evbuf u_evbuf
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_list (push_list),
        .buf_ready (buf_ready),
        .evt_valid (evt_valid),
        .evt_stall (evt_stall),
        .evt       (evt)
    );

endmodule
`default_nettype wire

FILE: tb/button_gesture_classifier_unit_tb.sv
// Self-checking testbench for the button gesture classifier: ticks in, gesture events checked.
module button_gesture_classifier_unit_tb;
    import bgc_pkg::*;

    localparam int CYCLE_LIMIT   = 1000000; // far above the slowest legal run
    localparam int SETTLE_CYCLES = 8;      // room for the block to settle
    localparam int LONG_HOLD     = 300;    // receiver hold-off for the back-pressure phase
    localparam int RANDOM_PHASES = 10;
    localparam int PHASE_TICKS   = 40;
    localparam int PRESSURE_TICKS = 80;
    localparam int PRESSURE_PHASE = 4;
    localparam int MAX_REPORTS   = 40;

    // ------------------------------------------------------------------
    // DUT signals, all driven to known values from time zero
    // ------------------------------------------------------------------
    logic              clk        = 1'b0;
    logic              rst_n      = 1'b0;
    logic              psel       = 1'b0;
    logic              penable    = 1'b0;
    logic              pwrite     = 1'b0;
    logic [ADDR_W-1:0] paddr      = '0;
    logic [DATA_W-1:0] pwdata     = '0;
    logic [DATA_W-1:0] prdata;
    logic              pready;
    logic              tick_valid = 1'b0;
    logic              tick_stall;
    tick_t             tick       = '0;
    logic              evt_valid;
    logic              evt_stall  = 1'b0;
    evt_t              evt;

    button_gesture_classifier_unit u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .tick_valid (tick_valid),
        .tick_stall (tick_stall),
        .tick       (tick),
        .evt_valid  (evt_valid),
        .evt_stall  (evt_stall),
        .evt        (evt)
    );

    // ------------------------------------------------------------------
    // Gesture predictor: its own copy of the registers and the timing state.
    // Time values are TIME_BITS_DEF wide so every difference wraps the same
    // way the block's counters do.
    // ------------------------------------------------------------------
    logic [9:0]  debounce_cfg   = DEBOUNCE_RST;
    logic [15:0] long_press_cfg = LONG_PRESS_RST;
    logic [11:0] double_tap_cfg = DOUBLE_TAP_RST;
    logic [7:0]  tap_margin_cfg = TAP_MARGIN_RST;

    logic [TIME_BITS_DEF-1:0] ms_now        = '0;
    logic [TIME_BITS_DEF-1:0] up_stamp      = '0;
    logic [TIME_BITS_DEF-1:0] down_stamp    = '0;
    logic [TIME_BITS_DEF-1:0] show_stamp    = '0;
    logic [TIME_BITS_DEF-1:0] press_stamp   = '0;
    logic [TIME_BITS_DEF-1:0] release_stamp = '0;
    logic [TIME_BITS_DEF-1:0] deadline_at   = '0;
    logic show_down   = 1'b0; // show button held
    logic long_done   = 1'b0; // long press already reported for this hold
    logic tap_pending = 1'b0; // a single tap waits for its timeout
    logic deadline_on = 1'b0;

    evt_t expected_events[$];
    int   gesture_count[0:4];

    // Bookkeeping shared by the processes
    tick_t pending_ticks[$];
    int    ticks_pushed   = 0;
    int    ticks_accepted = 0;
    int    events_checked = 0;
    int    errors         = 0;
    int    cycle_count    = 0;
    int    settings_used  = 1;
    logic  quiet          = 1'b0; // no gaps and no random stalls while set
    logic  hold_req       = 1'b0; // asks the event sink for one long hold-off
    logic  gen_level      = 1'b0; // show level the random generator believes in

    task automatic report_mismatch(input string what);
        errors++;
        if (errors <= MAX_REPORTS)
            $display("MISMATCH cycle %0d: %s", cycle_count, what);
    endtask

    // One millisecond tick: up, down, show edge, then the deadline check.
    task automatic classify_tick(input tick_t t);
        logic [2:0] found[$];
        logic [TIME_BITS_DEF-1:0] now;
        evt_t e;
        now = ms_now;
        // debounce: elapsed time since the last accepted edge of that button
        if (t.up_edge && (now - up_stamp) >= debounce_cfg) begin
            up_stamp = now;
            found.push_back(EV_UP);
        end
        if (t.down_edge && (now - down_stamp) >= debounce_cfg) begin
            down_stamp = now;
            found.push_back(EV_DOWN);
        end
        if (t.show_edge && (now - show_stamp) >= debounce_cfg) begin
            show_stamp = now;
            if (t.show_level) begin
                // a press (repeated or not) restarts the hold and the long-press deadline
                show_down   = 1'b1;
                long_done   = 1'b0;
                press_stamp = now;
                deadline_on = 1'b1;
                deadline_at = now + long_press_cfg;
            end
            else begin
                if (show_down && !long_done) begin
                    if (tap_pending && (now - release_stamp) <= double_tap_cfg) begin
                        tap_pending = 1'b0;
                        found.push_back(EV_DOUBLE);
                    end
                    else begin
                        tap_pending   = 1'b1;
                        release_stamp = now;
                        deadline_on   = 1'b1;
                        deadline_at   = now + double_tap_cfg + tap_margin_cfg;
                    end
                end
                show_down = 1'b0;
            end
        end
        if (deadline_on && deadline_at == now) begin
            deadline_on = 1'b0;
            if (show_down && !long_done && (now - press_stamp) >= long_press_cfg) begin
                long_done   = 1'b1;
                tap_pending = 1'b0;
                found.push_back(EV_LONG);
            end
            else if (tap_pending && (now - release_stamp) > double_tap_cfg) begin
                tap_pending = 1'b0;
                found.push_back(EV_TAP);
            end
            // with no margin the check can land right on the window edge:
            // the tap keeps waiting and nothing rearms the deadline
        end
        foreach (found[i]) begin
            e.event_code = found[i];
            e.last_event = (i == found.size() - 1);
            expected_events.push_back(e);
            gesture_count[found[i]]++;
        end
        ms_now = now + 1'b1;
    endtask

    // Mostly no gap, some short ones, a few long ones.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // ------------------------------------------------------------------
    // Clock and reset
    // ------------------------------------------------------------------
    initial
    begin
        forever #5 clk = ~clk;
    end

    // Run limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d events still expected",
                     cycle_count, expected_events.size());
            $display("button_gesture_classifier_unit_tb NOT OK");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Tick driver: takes items from pending_ticks, inserts random gaps,
    // holds the payload while the block stalls. Accepted items feed the
    // predictor at the accepting edge.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : tick_driver
        int gap_left;
        if (rst_n) begin
            if (tick_valid && !tick_stall) begin
                classify_tick(tick);
                ticks_accepted++;
            end
            if (!tick_valid || !tick_stall) begin
                if (gap_left > 0) begin
                    gap_left--;
                    tick_valid <= 1'b0;
                end
                else if (pending_ticks.size() > 0) begin
                    tick       <= pending_ticks.pop_front();
                    tick_valid <= 1'b1;
                    gap_left = quiet ? 0 : pick_gap();
                end
                else begin
                    tick_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Event monitor: checks each accepted item against the oldest
    // expectation and drives evt_stall (random stalls, plus one long
    // hold-off on request so the block backs up into tick_stall).
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : event_monitor
        evt_t want;
        int   stall_left;
        int   hold_left;
        if (rst_n) begin
            if (evt_valid && !evt_stall) begin
                if (expected_events.size() == 0) begin
                    report_mismatch($sformatf("event code %0d arrived with nothing expected",
                                              evt.event_code));
                end
                else begin
                    want = expected_events.pop_front();
                    if (evt.event_code !== want.event_code)
                        report_mismatch($sformatf("event_code %0d, expected %0d",
                                                  evt.event_code, want.event_code));
                    if (evt.last_event !== want.last_event)
                        report_mismatch($sformatf("last_event %0b, expected %0b (code %0d)",
                                                  evt.last_event, want.last_event,
                                                  want.event_code));
                    events_checked++;
                end
            end
            if (hold_req) begin
                hold_left = LONG_HOLD;
                hold_req <= 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                evt_stall <= 1'b1;
            end
            else if (stall_left > 0) begin
                stall_left--;
                evt_stall <= 1'b1;
            end
            else begin
                stall_left = quiet ? 0 : pick_gap();
                evt_stall <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic push_tick(input tick_t t);
        pending_ticks.push_back(t);
        ticks_pushed++;
    endtask

    // Wait until every item is taken and every event has come back, then
    // let the block settle.
    task automatic wait_idle();
        while (ticks_accepted != ticks_pushed || expected_events.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic logic [DATA_W-1:0] reg_value(input logic [1:0] idx);
        case (idx)
            REG_DEBOUNCE:   return DATA_W'(debounce_cfg);
            REG_LONG_PRESS: return DATA_W'(long_press_cfg);
            REG_DOUBLE_TAP: return DATA_W'(double_tap_cfg);
            default:        return DATA_W'(tap_margin_cfg);
        endcase
    endfunction

    // APB read in setup + access; prdata sampled at the completing edge.
    task automatic reg_check(input logic [1:0] idx);
        logic [DATA_W-1:0] want;
        want = reg_value(idx);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (prdata !== want)
            report_mismatch($sformatf("register %0d reads 0x%0h, expected 0x%0h",
                                      idx, prdata, want));
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // APB write; bits above the register width are sometimes junk and must be dropped.
    task automatic reg_write(input logic [1:0] idx, input logic [DATA_W-1:0] field, input int w);
        logic [DATA_W-1:0] value;
        value = field;
        if ($urandom_range(0, 1))
            value = value | (DATA_W'($urandom()) << w);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);   // register takes the value at this edge
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_DEBOUNCE:   debounce_cfg   = value[9:0];
            REG_LONG_PRESS: long_press_cfg = value[15:0];
            REG_DOUBLE_TAP: double_tap_cfg = value[11:0];
            default:        tap_margin_cfg = value[7:0];
        endcase
        reg_check(idx);
    endtask

    task automatic set_timing(input int deb, input int hold, input int dbl, input int margin);
        reg_write(REG_DEBOUNCE,   DATA_W'(deb),    10);
        reg_write(REG_LONG_PRESS, DATA_W'(hold),   16);
        reg_write(REG_DOUBLE_TAP, DATA_W'(dbl),    12);
        reg_write(REG_TAP_MARGIN, DATA_W'(margin), 8);
        settings_used++;
    endtask

    // Random ticks: show edges mostly alternate press/release (well-formed
    // gestures with random hold and gap lengths), the rest is noise.
    task automatic queue_random_ticks(input int count, input int show_rate, input int press_rate);
        tick_t t;
        for (int i = 0; i < count; i++) begin
            t.up_edge   = ($urandom_range(0, 99) < press_rate);
            t.down_edge = ($urandom_range(0, 99) < press_rate);
            t.show_edge = ($urandom_range(0, 99) < show_rate);
            if ($urandom_range(0, 9) < 8)
                t.show_level = !gen_level;
            else
                t.show_level = 1'($urandom_range(0, 1));
            if (t.show_edge)
                gen_level = t.show_level;
            push_tick(t);
        end
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial
    begin : stimulus
        int show_rate;
        int press_rate;
        foreach (gesture_count[i])
            gesture_count[i] = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // reset values of all four registers
        reg_check(REG_DEBOUNCE);
        reg_check(REG_LONG_PRESS);
        reg_check(REG_DOUBLE_TAP);
        reg_check(REG_TAP_MARGIN);

        // Defaults: edge stamps start at zero, so edges right after reset
        // fall inside the debounce window and are dropped.
        // tick bit order: {up_edge, down_edge, show_edge, show_level}
        push_tick(4'b1111);
        push_tick(4'b0010);
        push_tick(4'b1111);
        wait_idle();

        // Short timings so every gesture fits in a handful of ticks:
        // no debounce, long press 4, double-tap window 5, margin 2.
        set_timing(0, 4, 5, 2);
        push_tick(4'b1111);           // up + down + show press
        push_tick(4'b0010);           // quick release: tap starts waiting
        push_tick(4'b0011);           // second press
        push_tick(4'b1010);           // up + release inside window: double tap
        push_tick(4'b0010);           // release while not held: no event
        push_tick(4'b0011);           // press and hold ...
        repeat (4) push_tick(4'b0000);  // ... long press fires on the deadline
        push_tick(4'b0110);           // down + release after long press: nothing
        push_tick(4'b0011);
        push_tick(4'b0010);           // tap waits, deadline at release + 7
        repeat (8) push_tick(4'b0000);  // single tap times out
        push_tick(4'b0011);           // repeated press restarts the hold
        push_tick(4'b0011);
        wait_idle();

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            case (p)
                0: set_timing(0, 1, 1, 0);             // all minimums
                1: set_timing(1023, 65535, 4095, 255); // all maximums
                2: set_timing(2, 65535, 3, 0);         // margin 0: tap check on the edge
                3: set_timing(1023, 1, 1, 255);
                default:
                    set_timing($urandom_range(0, 4), $urandom_range(1, 30),
                               $urandom_range(1, 25),
                               ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8));
            endcase
            // the pressure phase sends back to back while the sink holds off
            quiet <= (p % 3 == 2) || (p == PRESSURE_PHASE);
            show_rate  = $urandom_range(10, 50);
            press_rate = $urandom_range(5, 40);
            if (p == PRESSURE_PHASE) begin
                hold_req <= 1'b1;
                queue_random_ticks(PRESSURE_TICKS, 40, 70);
            end
            else begin
                queue_random_ticks(PHASE_TICKS, show_rate, press_rate);
            end
            wait_idle();   // sender pauses until every event is back
        end

        $display("ran %0d ticks under %0d register settings, %0d events checked",
                 ticks_accepted, settings_used, events_checked);
        $display("events: %0d up, %0d down, %0d tap, %0d double tap, %0d long press",
                 gesture_count[EV_UP], gesture_count[EV_DOWN], gesture_count[EV_TAP],
                 gesture_count[EV_DOUBLE], gesture_count[EV_LONG]);
        if (errors == 0)
            $display("button_gesture_classifier_unit_tb OK");
        else
            $display("button_gesture_classifier_unit_tb NOT OK");
        $finish;
    end

endmodule
